// File: rtl/nms_pkg.sv
package nms_pkg;

  // Time values: unsigned 32.16 fixed point, raw 48-bit integers
  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Lookahead registers: raw 32-bit values in the same scale
  localparam int LA_W = 32;
  localparam int LA_SLOTS = 4;

  // Field widths fixed by the interface
  localparam int PRED_BITS = 16;
  localparam int SRC_W = 4;
  localparam int SLOT_W = 2;
  localparam int CNT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRED_MASK  = 3'd0,
    CFG_SUCC_COUNT = 3'd1,
    CFG_LA_SLOT_0  = 3'd2,
    CFG_LA_SLOT_1  = 3'd3,
    CFG_LA_SLOT_2  = 3'd4,
    CFG_LA_SLOT_3  = 3'd5
  } cfg_idx_t;

  // Input command codes
  localparam logic CMD_NULL = 1'b0;
  localparam logic CMD_REQ  = 1'b1;

  // Result kind codes
  localparam logic KIND_NULL    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [PRED_BITS-1:0]            pred_mask;
    logic [CNT_W-1:0]                succ_count;
    logic [LA_SLOTS-1:0][LA_W-1:0]   lookahead;
  } cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NULL_RD,
    ST_NULL_WR,
    ST_SCAN,
    ST_SUCC_RD,
    ST_SUCC_CMP,
    ST_VERDICT
  } state_t;

endpackage

// File: rtl/nms_in_if.sv
interface nms_in_if;
  import nms_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SRC_W-1:0]    source_lp;
  logic [TIME_W-1:0]   event_time;

  modport source (output valid, output cmd, output source_lp, output event_time,
                  input ready);
  modport sink (input valid, input cmd, input source_lp, input event_time,
                output ready);
endinterface

// File: rtl/nms_out_if.sv
interface nms_out_if;
  import nms_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [SLOT_W-1:0]   succ_slot;
  logic [TIME_W-1:0]   stamp;
  logic                safe;
  logic                last;

  modport source (output valid, output kind, output succ_slot, output stamp,
                  output safe, output last, input ready);
  modport sink (input valid, input kind, input succ_slot, input stamp,
                input safe, input last, output ready);
endinterface

// File: rtl/nms_ram.sv
module nms_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/nms_cfg_regs.sv
module nms_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [nms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output nms_pkg::cfg_t                  cfg
);
  import nms_pkg::*;

  // Register bank; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PRED_MASK:  cfg.pred_mask <= cfg_wdata[PRED_BITS-1:0];
        CFG_SUCC_COUNT: cfg.succ_count <= cfg_wdata[CNT_W-1:0];
        CFG_LA_SLOT_0:  cfg.lookahead[0] <= cfg_wdata[LA_W-1:0];
        CFG_LA_SLOT_1:  cfg.lookahead[1] <= cfg_wdata[LA_W-1:0];
        CFG_LA_SLOT_2:  cfg.lookahead[2] <= cfg_wdata[LA_W-1:0];
        CFG_LA_SLOT_3:  cfg.lookahead[3] <= cfg_wdata[LA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/null_message_time_synchronizer_core.sv
// Null-message time synchronizer for one logical process.
// Channels: item (sink) carries cmd, source_lp and event_time; result
// (source) carries kind, succ_slot, stamp, safe and last. Both use a
// valid/ready handshake; a transaction moves when both are high.
// Configuration: cfg_we/cfg_idx/cfg_wdata write pred_mask, succ_count and
// the four lookahead registers; write only while the block is idle.
// A null message (cmd 0) steps through accept, table read, and compare
// and write back. It produces no result.
// A request (cmd 1) scans min(MAX_PROCESSES,16) entries of the input-time
// memory, one entry per cycle, then does a read-modify-write of each
// active output-time slot. It yields one null message per raised slot and
// then a verdict with last set.
// One item is in work at a time; item.ready is high only between items.
// Results sit in an output register; when the receiver stalls the block
// holds the pending result and waits, so nothing is lost.
// Reset clears the valid bits of both tables (entries read as zero), the
// configuration registers and the output valid bit; no clearing pass.
module null_message_time_synchronizer_core #(
  parameter int MAX_PROCESSES  = 16,
  parameter int MAX_SUCCESSORS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nms_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [nms_pkg::CFG_DATA_W-1:0] cfg_wdata,
  nms_in_if.sink                         item,
  nms_out_if.source                      result
);
  import nms_pkg::*;

  localparam int PW = $clog2(MAX_PROCESSES);
  localparam int SW = MAX_SUCCESSORS > 1 ? $clog2(MAX_SUCCESSORS) : 1;
  localparam int NSCAN = MAX_PROCESSES < PRED_BITS ? MAX_PROCESSES : PRED_BITS;
  localparam int SCAN_W = $clog2(PRED_BITS + 1);
  localparam int EXT_W = 9;

  cfg_t cfg;

  nms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  state_t state, state_next;

  // Item and work registers
  logic [SRC_W-1:0]   src;
  logic [TIME_W-1:0]  t_item;
  logic [TIME_W-1:0]  earliest;
  logic               safe_acc;
  logic [SCAN_W-1:0]  scan_cnt;
  logic               scan_pend;
  logic [SRC_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   slot_cnt;

  // Table valid bits
  logic [MAX_PROCESSES-1:0]  in_vld;
  logic [MAX_SUCCESSORS-1:0] out_vld;
  logic                      in_rd_vld;
  logic                      out_rd_vld;

  // Memory ports
  logic               in_re, in_we;
  logic [PW-1:0]      in_raddr, in_waddr;
  logic [TIME_W-1:0]  in_rdata;
  logic               out_re, out_we;
  logic [SW-1:0]      out_addr;
  logic [TIME_W-1:0]  out_rdata;

  // Output register
  logic               res_valid;
  logic               res_kind;
  logic [SLOT_W-1:0]  res_slot;
  logic [TIME_W-1:0]  res_stamp;
  logic               res_safe;
  logic               res_last;
  logic               res_load_null, res_load_verdict;
  logic               res_free;

  logic [EXT_W-1:0]   src_ext, scan_ext;
  logic               src_ok;
  logic [TIME_W-1:0]  in_ent, out_ent;
  logic [CNT_W-1:0]   active;
  logic [TIME_W:0]    sum_full;
  logic [TIME_W-1:0]  sum_sat;
  logic               scan_take;

  nms_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCESSES)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (t_item),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  nms_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SUCCESSORS)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_addr),
    .wdata (sum_sat),
    .re    (out_re),
    .raddr (out_addr),
    .rdata (out_rdata)
  );

  // Address and entry values
  assign src_ext  = EXT_W'(src);
  assign scan_ext = EXT_W'(scan_cnt);
  assign src_ok   = src_ext < EXT_W'(MAX_PROCESSES);
  assign in_waddr = src_ext[PW-1:0];
  assign out_addr = slot_cnt[SW-1:0];
  assign in_ent   = in_rd_vld ? in_rdata : '0;
  assign out_ent  = out_rd_vld ? out_rdata : '0;
  assign active   = (cfg.succ_count > CNT_W'(MAX_SUCCESSORS)) ?
                    CNT_W'(MAX_SUCCESSORS) : cfg.succ_count;

  // Saturating sum of earliest and lookahead
  assign sum_full = {1'b0, earliest} + (TIME_W + 1)'(cfg.lookahead[slot_cnt[SLOT_W-1:0]]);
  assign sum_sat  = sum_full[TIME_W] ? TIME_MAX : sum_full[TIME_W-1:0];

  assign scan_take = scan_pend && cfg.pred_mask[rd_idx] && (in_ent < earliest);
  assign res_free  = !res_valid || result.ready;

  assign item.ready = (state == ST_IDLE);

  // Next state and strobes
  always_comb begin
    state_next       = state;
    in_re            = 1'b0;
    in_raddr         = in_waddr;
    in_we            = 1'b0;
    out_re           = 1'b0;
    out_we           = 1'b0;
    res_load_null    = 1'b0;
    res_load_verdict = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          state_next = (item.cmd == CMD_REQ) ? ST_SCAN : ST_NULL_RD;
        end
      end
      ST_NULL_RD: begin
        if (src_ok) begin
          in_re      = 1'b1;
          state_next = ST_NULL_WR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_NULL_WR: begin
        in_we      = t_item > in_ent;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_cnt < SCAN_W'(NSCAN)) begin
          in_re    = 1'b1;
          in_raddr = scan_ext[PW-1:0];
        end else if (!scan_pend) begin
          state_next = ST_SUCC_RD;
        end
      end
      ST_SUCC_RD: begin
        if (slot_cnt < active) begin
          out_re     = 1'b1;
          state_next = ST_SUCC_CMP;
        end else begin
          state_next = ST_VERDICT;
        end
      end
      ST_SUCC_CMP: begin
        if (sum_sat > out_ent) begin
          if (res_free) begin
            out_we        = 1'b1;
            res_load_null = 1'b1;
            state_next    = ST_SUCC_RD;
          end
        end else begin
          state_next = ST_SUCC_RD;
        end
      end
      ST_VERDICT: begin
        if (res_free) begin
          res_load_verdict = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item and advance the scan and slot counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
      scan_cnt  <= '0;
      slot_cnt  <= '0;
    end else begin
      if (state == ST_IDLE && item.valid) begin
        src       <= item.source_lp;
        t_item    <= item.event_time;
        earliest  <= item.event_time;
        safe_acc  <= 1'b1;
        scan_cnt  <= '0;
        scan_pend <= 1'b0;
        slot_cnt  <= '0;
      end
      if (state == ST_SCAN) begin
        scan_pend <= in_re;
        if (in_re) begin
          rd_idx   <= scan_cnt[SRC_W-1:0];
          scan_cnt <= scan_cnt + SCAN_W'(1);
        end
        if (scan_take) begin
          earliest <= in_ent;
          safe_acc <= 1'b0;
        end
      end
      if (state == ST_SUCC_CMP && state_next == ST_SUCC_RD) begin
        slot_cnt <= slot_cnt + CNT_W'(1);
      end
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= '0;
      out_vld <= '0;
    end else begin
      if (in_we) begin
        in_vld[in_waddr] <= 1'b1;
      end
      if (out_we) begin
        out_vld[out_addr] <= 1'b1;
      end
    end
  end

  // Track validity of the data in each read register
  always_ff @(posedge clk) begin
    if (in_re) begin
      in_rd_vld <= in_vld[in_raddr];
    end
    if (out_re) begin
      out_rd_vld <= out_vld[out_addr];
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load_null || res_load_verdict) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load_null) begin
      res_kind  <= KIND_NULL;
      res_slot  <= slot_cnt[SLOT_W-1:0];
      res_stamp <= sum_sat;
      res_safe  <= 1'b0;
      res_last  <= 1'b0;
    end else if (res_load_verdict) begin
      res_kind  <= KIND_VERDICT;
      res_slot  <= '0;
      res_stamp <= earliest;
      res_safe  <= safe_acc;
      res_last  <= 1'b1;
    end
  end

  assign result.valid     = res_valid;
  assign result.kind      = res_kind;
  assign result.succ_slot = res_slot;
  assign result.stamp     = res_stamp;
  assign result.safe      = res_safe;
  assign result.last      = res_last;

endmodule
